// File: sv/fan_compressor_interlock_timer_macros.svh
// Assertion macros for the fan/compressor interlock timer.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef FAN_COMPRESSOR_INTERLOCK_TIMER_MACROS_SVH
`define FAN_COMPRESSOR_INTERLOCK_TIMER_MACROS_SVH

`ifndef SYNTHESIS
// Check that is switched off while reset is asserted.
`define FCIT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that is evaluated during reset too.
`define FCIT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FCIT_ASSERT(lbl, clk, rst_n, prop, msg)
`define FCIT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: sv/fcit_pkg.sv
// Shared types and constants for the fan/compressor interlock timer.
// No dependencies; imported by the interfaces' users, the core and the top level.
package fcit_pkg;

  localparam int unsigned TimerW = 16;

  // command codes
  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_FAN      = 2'd1,
    OP_COMP     = 2'd2,
    OP_FAN_HOLD = 2'd3
  } op_e;

  // compressor request codes
  localparam logic [1:0] COMP_REQ_OFF = 2'd0;
  localparam logic [1:0] COMP_REQ_ON  = 2'd1;
  localparam logic [1:0] FAN_OFF      = 2'd0;

  // register indexes
  localparam logic [1:0] REG_FAN_SWITCH_HOLD = 2'd0;
  localparam logic [1:0] REG_RESTART_DELAY   = 2'd1;
  localparam logic [1:0] REG_MIN_RUN         = 2'd2;
  localparam logic [1:0] REG_FAN_RUN_HOLD    = 2'd3;

  // register reset values, in ticks
  localparam logic [TimerW-1:0] FanSwitchHoldRst = 16'd2000;
  localparam logic [TimerW-1:0] RestartDelayRst  = 16'd30000;
  localparam logic [TimerW-1:0] MinRunRst        = 16'd15000;
  localparam logic [TimerW-1:0] FanRunHoldRst    = 16'd30000;

  typedef struct packed {
    logic [TimerW-1:0] fan_switch_hold;
    logic [TimerW-1:0] restart_delay;
    logic [TimerW-1:0] min_run;
    logic [TimerW-1:0] fan_run_hold;
  } cfg_t;

  typedef struct packed {
    logic [TimerW-1:0] fan_switch_left;
    logic [TimerW-1:0] restart_left;
    logic [TimerW-1:0] min_run_left;
    logic [TimerW-1:0] fan_hold_left;
    logic              comp_on;
    logic [1:0]        fan;
  } state_t;

  typedef struct packed {
    logic [1:0] fan_speed;
    logic       compressor_on;
    logic       accepted;
  } result_t;

endpackage

// File: sv/fcit_if.sv
// Valid/ready stream interfaces for the command and result channels.
// Standalone; payload widths follow the command and result fields.
interface fcit_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface fcit_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] fan_speed;
  logic       compressor_on;
  logic       accepted;

  modport source (output valid, output fan_speed, output compressor_on, output accepted,
                  input ready);
  modport sink   (input valid, input fan_speed, input compressor_on, input accepted,
                  output ready);
endinterface

// File: sv/fcit_core.sv
// Next-state and result logic for one command of the interlock timer.
// Depends on fcit_pkg; purely combinational, the top level holds the state.
module fcit_core (
  input  fcit_pkg::state_t  state_i,
  input  fcit_pkg::cfg_t    cfg_i,
  input  logic [1:0]        op_i,
  input  logic [1:0]        value_i,
  output fcit_pkg::state_t  state_o,
  output fcit_pkg::result_t result_o
);
  import fcit_pkg::*;

  logic fan_switch_zero;
  logic restart_zero;
  logic min_run_zero;
  logic fan_hold_zero;
  logic ok;

  assign fan_switch_zero = (state_i.fan_switch_left == '0);
  assign restart_zero    = (state_i.restart_left == '0);
  assign min_run_zero    = (state_i.min_run_left == '0);
  assign fan_hold_zero   = (state_i.fan_hold_left == '0);

  always_comb begin
    state_o = state_i;
    ok      = 1'b0;
    case (op_e'(op_i))
      OP_TICK: begin
        // saturating countdown of every timer
        if (!fan_switch_zero) state_o.fan_switch_left = state_i.fan_switch_left - 1'b1;
        if (!restart_zero)    state_o.restart_left    = state_i.restart_left - 1'b1;
        if (!min_run_zero)    state_o.min_run_left    = state_i.min_run_left - 1'b1;
        if (!fan_hold_zero)   state_o.fan_hold_left   = state_i.fan_hold_left - 1'b1;
      end
      OP_FAN: begin
        if (value_i == FAN_OFF) begin
          if (fan_hold_zero && !state_i.comp_on) begin
            state_o.fan = FAN_OFF;
            ok          = 1'b1;
          end
        end else if (fan_switch_zero) begin
          state_o.fan_switch_left = cfg_i.fan_switch_hold;
          state_o.fan             = value_i;
          ok                      = 1'b1;
        end
      end
      OP_COMP: begin
        if (value_i == COMP_REQ_OFF) begin
          // off while already off still restarts the delay
          if (min_run_zero) begin
            state_o.comp_on      = 1'b0;
            state_o.restart_left = cfg_i.restart_delay;
            ok                   = 1'b1;
          end
        end else if (value_i == COMP_REQ_ON) begin
          if (!state_i.comp_on && restart_zero) begin
            state_o.comp_on      = 1'b1;
            state_o.min_run_left = cfg_i.min_run;
            ok                   = 1'b1;
          end
        end
      end
      OP_FAN_HOLD: begin
        if (fan_hold_zero) begin
          state_o.fan_hold_left = cfg_i.fan_run_hold;
          ok                    = 1'b1;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign result_o.fan_speed     = state_o.fan;
  assign result_o.compressor_on = state_o.comp_on;
  assign result_o.accepted      = ok;

endmodule

// File: sv/fan_compressor_interlock_timer.sv
// Fan/compressor interlock timer: config registers, state, result buffering.
// Depends on fcit_pkg, fcit_if.sv, fcit_core and the assertion macro header.
//
// Usage:
//   Commands enter on in_ch (op, value); each transfer yields exactly one
//   result on out_ch (fan_speed, compressor_on, accepted), in order.
//   op 0 is a one-millisecond tick that counts every nonzero timer down;
//   ops 1..3 set fan speed, request the compressor, or start the fan run hold.
//   The result is registered: it enters the result register, or the skid entry while the output is stalled.
//   Throughput: one command per cycle while the skid entry is empty; the state update is a single pass of
//   compare/decrement/load logic between the state registers.
//   A result register plus one skid entry sit on the output: a stalled
//   receiver is absorbed by the skid entry, and in_ch.ready drops only while
//   that entry is full. No result is dropped or repeated.
//   Reset (rst_ni low, asynchronous) clears all timers, turns fan and
//   compressor off, empties the output buffer and loads the default hold
//   times into the four registers (APB, byte addresses 0, 4, 8, 12).
//   Registers must be written only while no command is in flight; the block itself does not enforce it.
`include "fan_compressor_interlock_timer_macros.svh"

module fan_compressor_interlock_timer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  fcit_in_if.sink     in_ch,
  fcit_out_if.source  out_ch
);
  import fcit_pkg::*;

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  result_t res;
  result_t out_q, skid_q;
  logic    out_v_q, skid_v_q;
  logic    in_fire, out_fire, cfg_wr;
  logic [1:0] reg_idx;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fan_switch_hold <= FanSwitchHoldRst;
      cfg_q.restart_delay   <= RestartDelayRst;
      cfg_q.min_run         <= MinRunRst;
      cfg_q.fan_run_hold    <= FanRunHoldRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FAN_SWITCH_HOLD: cfg_q.fan_switch_hold <= pwdata[TimerW-1:0];
        REG_RESTART_DELAY:   cfg_q.restart_delay   <= pwdata[TimerW-1:0];
        REG_MIN_RUN:         cfg_q.min_run         <= pwdata[TimerW-1:0];
        REG_FAN_RUN_HOLD:    cfg_q.fan_run_hold    <= pwdata[TimerW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FAN_SWITCH_HOLD: prdata = {16'd0, cfg_q.fan_switch_hold};
      REG_RESTART_DELAY:   prdata = {16'd0, cfg_q.restart_delay};
      REG_MIN_RUN:         prdata = {16'd0, cfg_q.min_run};
      REG_FAN_RUN_HOLD:    prdata = {16'd0, cfg_q.fan_run_hold};
      default:             prdata = '0;
    endcase
  end

  // ---------------- command processing ----------------
  assign in_ch.ready = !skid_v_q;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_v_q && out_ch.ready;

  fcit_core u_core (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .op_i     (in_ch.op),
    .value_i  (in_ch.value),
    .state_o  (state_d),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // result register with one skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_fire) begin
      out_v_q  <= skid_v_q || in_fire;
      skid_v_q <= 1'b0;
    end else if (in_fire) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_fire) begin
      out_q <= skid_v_q ? skid_q : res;
    end
    if (in_fire) begin
      skid_q <= res;
    end
  end

  assign out_ch.valid         = out_v_q;
  assign out_ch.fan_speed     = out_q.fan_speed;
  assign out_ch.compressor_on = out_q.compressor_on;
  assign out_ch.accepted      = out_q.accepted;

  // ---------------- checks ----------------
  `FCIT_ASSERT(a_skid_behind_out, clk_i, rst_ni, skid_v_q |-> out_v_q, "skid full, output empty")
  `FCIT_ASSERT(a_comp_on_after_delay, clk_i, rst_ni,
               $rose(state_q.comp_on) |-> $past(state_q.restart_left == '0),
               "compressor started during restart delay")
  `FCIT_ASSERT(a_comp_off_after_run, clk_i, rst_ni,
               $fell(state_q.comp_on) |-> $past(state_q.min_run_left == '0),
               "compressor stopped before minimum run")
  `FCIT_ASSERT(a_fan_switch_hold, clk_i, rst_ni,
               ((state_q.fan != $past(state_q.fan)) && (state_q.fan != FAN_OFF))
                 |-> $past(state_q.fan_switch_left == '0),
               "fan speed changed during switch hold")
  `FCIT_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> (!out_v_q && !skid_v_q),
                      "output buffer not empty in reset")

endmodule

// File: sim/fan_compressor_interlock_timer_tb.sv
// Testbench for the fan/compressor interlock timer: relay commands and ticks in, relay state out.
// Depends on fcit_pkg, the stream interfaces in fcit_if.sv and the top level
// fan_compressor_interlock_timer.
`timescale 1ns / 100ps

module fan_compressor_interlock_timer_tb;
  import fcit_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fcit_in_if  cmd_ch ();
  fcit_out_if res_ch ();

  fan_compressor_interlock_timer dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (cmd_ch),
    .out_ch  (res_ch)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Relay controller mirror: hold times and countdowns
  cfg_t              hold_cfg;
  logic [TimerW-1:0] fan_switch_cnt;
  logic [TimerW-1:0] restart_cnt;
  logic [TimerW-1:0] min_run_cnt;
  logic [TimerW-1:0] run_hold_cnt;
  logic              comp_relay;
  logic [1:0]        fan_relay;

  result_t     relay_expect_q[$];
  int unsigned err_count;
  int unsigned burst_left;
  bit          sink_hold_req;

  function automatic logic [TimerW-1:0] count_down(logic [TimerW-1:0] t);
    return (t != '0) ? t - 1'b1 : '0;
  endfunction

  // Applies one command to the mirror and returns the relay state and accepted flag
  function automatic result_t relay_step(op_e op, logic [1:0] value);
    result_t r;
    logic    ok;
    ok = 1'b0;
    case (op)
      OP_TICK: begin
        fan_switch_cnt = count_down(fan_switch_cnt);
        restart_cnt    = count_down(restart_cnt);
        min_run_cnt    = count_down(min_run_cnt);
        run_hold_cnt   = count_down(run_hold_cnt);
      end
      OP_FAN: begin
        if (value == FAN_OFF) begin
          if (run_hold_cnt == '0 && !comp_relay) begin
            fan_relay = FAN_OFF;
            ok = 1'b1;
          end
        end else if (fan_switch_cnt == '0) begin
          fan_switch_cnt = hold_cfg.fan_switch_hold;
          fan_relay = value;
          ok = 1'b1;
        end
      end
      OP_COMP: begin
        if (value == COMP_REQ_OFF) begin
          // off is allowed again while already off; it reloads the restart delay
          if (min_run_cnt == '0) begin
            comp_relay = 1'b0;
            restart_cnt = hold_cfg.restart_delay;
            ok = 1'b1;
          end
        end else if (value == COMP_REQ_ON) begin
          if (!comp_relay && restart_cnt == '0) begin
            comp_relay = 1'b1;
            min_run_cnt = hold_cfg.min_run;
            ok = 1'b1;
          end
        end
      end
      default: begin
        if (run_hold_cnt == '0) begin
          run_hold_cnt = hold_cfg.fan_run_hold;
          ok = 1'b1;
        end
      end
    endcase
    r.fan_speed     = fan_relay;
    r.compressor_on = comp_relay;
    r.accepted      = ok;
    return r;
  endfunction

  task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    err_count++;
  endtask

  // ---------------------------------------------------------------- APB
  task automatic apb_xfer(logic wr, logic [1:0] idx, logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_reg(logic [1:0] idx, logic [TimerW-1:0] want);
    logic [31:0] rd;
    apb_xfer(1'b0, idx, '0, rd);
    if (rd[TimerW-1:0] !== want) begin
      flag_mismatch($sformatf("register %0d readback", idx), want, rd[TimerW-1:0]);
    end
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [TimerW-1:0] val);
    logic [31:0] rd;
    apb_xfer(1'b1, idx, {16'h0, val}, rd);
    case (idx)
      REG_FAN_SWITCH_HOLD: hold_cfg.fan_switch_hold = val;
      REG_RESTART_DELAY:   hold_cfg.restart_delay = val;
      REG_MIN_RUN:         hold_cfg.min_run = val;
      REG_FAN_RUN_HOLD:    hold_cfg.fan_run_hold = val;
      default: ;
    endcase
    check_reg(idx, val);
  endtask

  task automatic cfg_write_all(logic [TimerW-1:0] sw, logic [TimerW-1:0] rd,
                               logic [TimerW-1:0] mr, logic [TimerW-1:0] fh);
    cfg_write(REG_FAN_SWITCH_HOLD, sw);
    cfg_write(REG_RESTART_DELAY, rd);
    cfg_write(REG_MIN_RUN, mr);
    cfg_write(REG_FAN_RUN_HOLD, fh);
  endtask

  // ---------------------------------------------------------------- command side
  // Caller sits on a rising edge; valid is left high after the transfer
  task automatic send_cmd(op_e op, logic [1:0] value);
    cmd_ch.valid <= 1'b1;
    cmd_ch.op    <= op;
    cmd_ch.value <= value;
    do @(posedge clk_i); while (!cmd_ch.ready);
    relay_expect_q.push_back(relay_step(op, value));
  endtask

  task automatic send_item(op_e op, logic [1:0] value);
    send_cmd(op, value);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // Half the items are ticks so the countdowns actually expire between commands
  task automatic send_random_item();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      send_item(OP_TICK, 2'($urandom_range(0, 3)));
    end else if (pick < 7) begin
      send_item(OP_FAN, 2'($urandom_range(0, 3)));
    end else if (pick < 9) begin
      if ($urandom_range(0, 6) == 0) send_item(OP_COMP, 2'($urandom_range(2, 3)));
      else send_item(OP_COMP, 2'($urandom_range(0, 1)));
    end else begin
      send_item(OP_FAN_HOLD, 2'($urandom_range(0, 3)));
    end
  endtask

  task automatic wait_drained();
    if (cmd_ch.valid) cmd_ch.valid <= 1'b0;
    while (relay_expect_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  function automatic logic [TimerW-1:0] pick_hold();
    return ($urandom_range(0, 5) == 0) ? '0 : TimerW'($urandom_range(1, 30));
  endfunction

  // ---------------------------------------------------------------- result side
  initial begin : result_sink
    int unsigned cyc;
    int unsigned mode;
    int unsigned hold_cnt;
    cyc = 0;
    mode = 0;
    hold_cnt = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 50 == 0) mode = $urandom_range(0, 3);
      if (sink_hold_req) begin
        hold_cnt = 60;
        sink_hold_req = 1'b0;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        res_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       res_ch.ready <= 1'b1;
          1:       res_ch.ready <= (cyc % 3) != 0;
          2:       res_ch.ready <= 1'($urandom_range(0, 1));
          default: res_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (relay_expect_q.size() == 0) begin
        $display("%0t: result transfer with nothing expected", $time);
        err_count++;
      end else begin
        want = relay_expect_q.pop_front();
        if (res_ch.fan_speed !== want.fan_speed)
          flag_mismatch("fan_speed", want.fan_speed, res_ch.fan_speed);
        if (res_ch.compressor_on !== want.compressor_on)
          flag_mismatch("compressor_on", want.compressor_on, res_ch.compressor_on);
        if (res_ch.accepted !== want.accepted)
          flag_mismatch("accepted", want.accepted, res_ch.accepted);
      end
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_register_defaults();
    check_reg(REG_FAN_SWITCH_HOLD, FanSwitchHoldRst);
    check_reg(REG_RESTART_DELAY, RestartDelayRst);
    check_reg(REG_MIN_RUN, MinRunRst);
    check_reg(REG_FAN_RUN_HOLD, FanRunHoldRst);
  endtask

  task automatic test_directed();
    cfg_write_all(16'd2, 16'd3, 16'd2, 16'd0);
    send_item(OP_FAN, FAN_OFF);
    send_item(OP_FAN, 2'd3);
    send_item(OP_FAN, 2'd1);          // switch hold still running
    send_item(OP_TICK, 2'd0);
    send_item(OP_TICK, 2'd3);         // value is don't-care on ticks
    send_item(OP_FAN, 2'd1);
    send_item(OP_COMP, COMP_REQ_ON);
    send_item(OP_COMP, COMP_REQ_ON);  // already on
    send_item(OP_COMP, COMP_REQ_OFF); // min run not over
    send_item(OP_FAN, FAN_OFF);       // compressor still on
    send_item(OP_COMP, 2'd2);
    send_item(OP_COMP, 2'd3);
    send_item(OP_TICK, 2'd1);
    send_item(OP_TICK, 2'd2);
    send_item(OP_COMP, COMP_REQ_OFF);
    send_item(OP_COMP, COMP_REQ_OFF); // off again reloads restart delay
    send_item(OP_COMP, COMP_REQ_ON);  // restart delay running
    send_item(OP_FAN_HOLD, 2'd0);     // zero hold expires at once
    send_item(OP_FAN_HOLD, 2'd3);
    send_item(OP_FAN, FAN_OFF);
    wait_drained();
    cfg_write(REG_FAN_RUN_HOLD, 16'd5);
    send_item(OP_FAN_HOLD, 2'd1);
    send_item(OP_FAN_HOLD, 2'd2);     // hold already running
    send_item(OP_FAN, 2'd2);
    send_item(OP_FAN, FAN_OFF);       // blocked by run hold
    wait_drained();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 8; p++) begin
      if (p == 0) cfg_write_all('0, '0, '0, '0);
      else cfg_write_all(pick_hold(), pick_hold(), pick_hold(), pick_hold());
      repeat (145) send_random_item();
      wait_drained();
    end
  endtask

  // Receiver holds off while commands keep coming, so the output buffer fills
  task automatic test_backpressure();
    cfg_write_all(16'd4, 16'd6, 16'd5, 16'd7);
    sink_hold_req = 1'b1;
    repeat (40) begin
      if ($urandom_range(0, 1) != 0) send_cmd(OP_TICK, 2'($urandom_range(0, 3)));
      else send_cmd(op_e'($urandom_range(1, 3)), 2'($urandom_range(0, 3)));
    end
    wait_drained();
  endtask

  task automatic test_max_hold();
    cfg_write_all('1, '1, '1, '1);
    send_item(OP_FAN, 2'd2);
    send_item(OP_COMP, COMP_REQ_ON);
    send_item(OP_FAN_HOLD, 2'd0);
    send_item(OP_COMP, COMP_REQ_OFF);
    repeat (20) send_random_item();
    wait_drained();
  endtask

  initial begin
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.op    = OP_TICK;
    cmd_ch.value = '0;
    err_count    = 0;
    burst_left   = 0;
    sink_hold_req = 1'b0;
    hold_cfg.fan_switch_hold = FanSwitchHoldRst;
    hold_cfg.restart_delay   = RestartDelayRst;
    hold_cfg.min_run         = MinRunRst;
    hold_cfg.fan_run_hold    = FanRunHoldRst;
    fan_switch_cnt = '0;
    restart_cnt    = '0;
    min_run_cnt    = '0;
    run_hold_cnt   = '0;
    comp_relay     = 1'b0;
    fan_relay      = FAN_OFF;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_defaults();
    test_directed();
    test_random_phases();
    test_backpressure();
    test_max_hold();

    wait_drained();
    if (err_count == 0 && relay_expect_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
